// ===== hw/rtl/gn3_pkg.sv =====
`timescale 1ns / 1ps
package gn3_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = 8;
  localparam int FRAC_W      = 16;   // internal Q0.16 fraction
  localparam int OFS_W       = 18;   // corner offset, f or f - 1.0
  localparam int GRAD_W      = 19;   // gradient and blend values
  localparam int QH_W        = 20;   // high part of the fade polynomial

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [3:0] HASH_U_Y  = 4'd8;
  localparam logic [3:0] HASH_V_Y  = 4'd4;
  localparam logic [3:0] HASH_V_XA = 4'd12;
  localparam logic [3:0] HASH_V_XB = 4'd14;

  localparam logic [QH_W:0] FADE_C10 = (QH_W+1)'(10 * 65536);

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [FRAC_W-1:0]        frac_t;
  typedef logic signed [OFS_W-1:0]  ofs_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  // Dot product of the offsets with the edge direction that hash h selects; some h values repeat a direction.
  function automatic grad_t grad(input logic [3:0] h, input ofs_t x, input ofs_t y,
                                 input ofs_t z);
    ofs_t  u;
    ofs_t  v;
    grad_t su;
    grad_t sv;
    u  = (h < HASH_U_Y) ? x : y;
    v  = (h < HASH_V_Y) ? y : ((h == HASH_V_XA || h == HASH_V_XB) ? x : z);
    su = h[0] ? -grad_t'(u) : grad_t'(u);
    sv = h[1] ? -grad_t'(v) : grad_t'(v);
    return su + sv;
  endfunction

  // a + floor(t * (b - a) / 2^16)
  function automatic grad_t lerp(input frac_t t, input grad_t a, input grad_t b);
    logic signed [GRAD_W:0]          diff;
    logic signed [GRAD_W+FRAC_W+1:0] prod;
    diff = (GRAD_W+1)'(b) - (GRAD_W+1)'(a);
    prod = diff * $signed({1'b0, t});
    return a + GRAD_W'(prod >>> FRAC_W);
  endfunction

endpackage

// ===== hw/rtl/gradient_noise_3d.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Ports                                          | Handshake
// item    | in        | op_i entry_index_i entry_value_i coord_[xyz]_i | start_i && !busy_o
// result  | out       | noise_value_o                                  | done_o, one cycle
//
// One item per cycle. The pipeline depth is set by three chained table lookups
// and the three blend multipliers.
// busy_o stays low: writes travel the pipeline and update each table copy at the
// stage that reads it, so earlier items still see the old contents.
// Reset clears only the stage valid bits and the stage 1 and 2 op bits; the table is undefined until written.
module gradient_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic [7:0]         entry_index_i,
  input  logic [7:0]         entry_value_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  output logic               done_o,
  output logic signed [15:0] noise_value_o
);

  localparam int DEPTH = gn3_pkg::TABLE_DEPTH;

  logic accept;
  logic [2:0][31:0] coord;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign coord  = {coord_z_i, coord_y_i, coord_x_i};

  // table copies: one at level 1, two at level 2, four at level 3
  logic [7:0] tbl1 [DEPTH];
  logic [7:0] tbl2 [2][DEPTH];
  logic [7:0] tbl3 [4][DEPTH];

  // stage valid bits
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, s6_vld_q, s7_vld_q, s8_vld_q;
  logic s1_op_q, s2_op_q;

  // stage 1
  gn3_pkg::idx_t s1_idx_q, s1_val_q;
  gn3_pkg::idx_t [2:0] s1_cell_d, s1_cell_q;
  gn3_pkg::frac_t [2:0] s1_frac_d, s1_frac_q;
  gn3_pkg::idx_t [1:0] l1_q;
  // stage 2
  gn3_pkg::idx_t s2_idx_q, s2_val_q, s2_cz_q;
  gn3_pkg::frac_t [2:0] s2_frac_q;
  logic [2:0][31:0] ff_d, ff_q;
  gn3_pkg::idx_t [1:0][1:0] l2_q;
  gn3_pkg::idx_t [1:0] a2_d;
  // stage 3
  gn3_pkg::frac_t [2:0] s3_frac_q, m2_d, m2_q;
  logic [2:0][gn3_pkg::QH_W-1:0] qh_d, qh_q;
  gn3_pkg::idx_t [3:0] a3_d;
  gn3_pkg::idx_t [3:0][1:0] h3_q;
  // stage 4
  gn3_pkg::grad_t [7:0] g_d, g_q;
  gn3_pkg::frac_t [2:0] fade_d, fade_q;
  // stage 5..8
  gn3_pkg::grad_t [3:0] lx_d, lx_q;
  gn3_pkg::grad_t [1:0] ly_d, ly_q;
  gn3_pkg::grad_t lz_d, lz_q;
  gn3_pkg::frac_t s5_v_q, s5_w_q, s6_w_q;
  logic signed [15:0] out_d, out_q;

  // split coordinates into cell and Q0.16 fraction
  always_comb begin
    logic [31:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh = coord[i] << (32 - FRAC_BITS);
      s1_frac_d[i] = sh[31:16];
      s1_cell_d[i] = coord[i][FRAC_BITS +: gn3_pkg::IDX_W];
    end
  end

  // level 1 table: written by the item at acceptance, read at X and X+1
  always_ff @(posedge clk_i) begin
    if (accept && op_i == gn3_pkg::OP_WRITE) begin
      tbl1[entry_index_i] <= entry_value_i;
    end
    l1_q[0] <= tbl1[s1_cell_d[0]];
    l1_q[1] <= tbl1[s1_cell_d[0] + 8'd1];
  end

  // level 2 tables
  assign a2_d[0] = l1_q[0] + s1_cell_q[1];
  assign a2_d[1] = l1_q[1] + s1_cell_q[1];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      if (s1_vld_q && s1_op_q == gn3_pkg::OP_WRITE) begin
        tbl2[k][s1_idx_q] <= s1_val_q;
      end
      l2_q[k][0] <= tbl2[k][a2_d[k]];
      l2_q[k][1] <= tbl2[k][a2_d[k] + 8'd1];
    end
  end

  // level 3 tables, copies ordered AA, BA, AB, BB
  assign a3_d[0] = l2_q[0][0] + s2_cz_q;
  assign a3_d[1] = l2_q[1][0] + s2_cz_q;
  assign a3_d[2] = l2_q[0][1] + s2_cz_q;
  assign a3_d[3] = l2_q[1][1] + s2_cz_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (s2_vld_q && s2_op_q == gn3_pkg::OP_WRITE) begin
        tbl3[k][s2_idx_q] <= s2_val_q;
      end
      h3_q[k][0] <= tbl3[k][a3_d[k]];
      h3_q[k][1] <= tbl3[k][a3_d[k] + 8'd1];
    end
  end

  // fade curve: square, then cube and polynomial, then final product
  always_comb begin
    logic [34:0] six_ff;
    logic [gn3_pkg::QH_W:0] lin;
    logic [31:0] cube;
    logic [35:0] prod;
    for (int i = 0; i < 3; i++) begin
      ff_d[i]   = 32'(s1_frac_q[i]) * 32'(s1_frac_q[i]);
      cube      = 32'(ff_q[i][31:16]) * 32'(s2_frac_q[i]);
      m2_d[i]   = cube[31:16];
      six_ff    = 35'(ff_q[i]) * 35'd6;
      lin       = (gn3_pkg::QH_W+1)'(s2_frac_q[i]) * (gn3_pkg::QH_W+1)'(15);
      qh_d[i]   = gn3_pkg::QH_W'(gn3_pkg::FADE_C10 - lin + (gn3_pkg::QH_W+1)'(six_ff[34:16]));
      prod      = 36'(m2_q[i]) * 36'(qh_q[i]);
      fade_d[i] = prod[31:16];
    end
  end

  // corner gradients; corner bit 0/1/2 selects the far side in x/y/z
  always_comb begin
    gn3_pkg::ofs_t [2:0] o;
    for (int c = 0; c < 8; c++) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = $signed({2'b00, s3_frac_q[i]}) - (c[i] ? 18'sd65536 : 18'sd0);
      end
      g_d[c] = gn3_pkg::grad(h3_q[c % 4][c / 4][3:0], o[0], o[1], o[2]);
    end
  end

  always_comb begin
    logic signed [16:0] r;
    for (int i = 0; i < 4; i++) begin
      lx_d[i] = gn3_pkg::lerp(fade_q[0], g_q[2*i], g_q[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      ly_d[i] = gn3_pkg::lerp(s5_v_q, lx_q[2*i], lx_q[2*i+1]);
    end
    lz_d = gn3_pkg::lerp(s6_w_q, ly_q[0], ly_q[1]);
    r = 17'(lz_q >>> 2);
    if (r > 17'sd32767) begin
      out_d = 16'sd32767;
    end else if (r < -17'sd32768) begin
      out_d = -16'sd32768;
    end else begin
      out_d = 16'(r);
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    s1_idx_q  <= entry_index_i;
    s1_val_q  <= entry_value_i;
    s1_cell_q <= s1_cell_d;
    s1_frac_q <= s1_frac_d;
    s2_idx_q  <= s1_idx_q;
    s2_val_q  <= s1_val_q;
    s2_cz_q   <= s1_cell_q[2];
    s2_frac_q <= s1_frac_q;
    ff_q      <= ff_d;
    s3_frac_q <= s2_frac_q;
    m2_q      <= m2_d;
    qh_q      <= qh_d;
    g_q       <= g_d;
    fade_q    <= fade_d;
    lx_q      <= lx_d;
    s5_v_q    <= fade_q[1];
    s5_w_q    <= fade_q[2];
    ly_q      <= ly_d;
    s6_w_q    <= s5_w_q;
    lz_q      <= lz_d;
    out_q     <= out_d;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
      s8_vld_q <= 1'b0;
      s1_op_q  <= gn3_pkg::OP_WRITE;
      s2_op_q  <= gn3_pkg::OP_WRITE;
    end else begin
      s1_vld_q <= accept;
      s1_op_q  <= op_i;
      s2_vld_q <= s1_vld_q;
      s2_op_q  <= s1_op_q;
      // drop write items once the last table copy has them
      s3_vld_q <= s2_vld_q && s2_op_q == gn3_pkg::OP_EVAL;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
      s8_vld_q <= s7_vld_q;
    end
  end

  assign done_o        = s8_vld_q;
  assign noise_value_o = out_q;

  a_eval_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == gn3_pkg::OP_EVAL) |-> ##8 done_o)
    else $error("evaluate item gave no result after eight cycles");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == gn3_pkg::OP_WRITE) |-> ##8 !done_o)
    else $error("write item produced a result");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(s2_vld_q && s2_op_q == gn3_pkg::OP_EVAL, 6))
    else $error("result without an evaluate item in flight");

endmodule

// ===== verif/gradient_noise_3d_tb.sv =====
`timescale 1ns / 1ps
module gradient_noise_3d_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 400;
  localparam int MAX_SHOWN      = 10;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               op_i;
  logic [7:0]         entry_index_i;
  logic [7:0]         entry_value_i;
  logic signed [31:0] coord_x_i;
  logic signed [31:0] coord_y_i;
  logic signed [31:0] coord_z_i;
  logic               done_o;
  logic signed [15:0] noise_value_o;

  gradient_noise_3d u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .op_i(op_i), .entry_index_i(entry_index_i), .entry_value_i(entry_value_i),
    .coord_x_i(coord_x_i), .coord_y_i(coord_y_i), .coord_z_i(coord_z_i),
    .done_o(done_o), .noise_value_o(noise_value_o)
  );

  typedef struct {
    logic        op;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    bit          has_known;
    logic [15:0] known;
  } noise_item_t;

  logic [7:0]  perm_model [256];
  logic [15:0] noise_expected_q [$];
  int          err_count;
  int          idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint floor_div(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint fade_curve(longint f);
    longint q;
    longint m;
    longint m2;
    q  = 6 * f * f + 10 * 65536 * 65536 - 15 * f * 65536;
    m  = (f * f) >> 16;
    m2 = (m * f) >> 16;
    return (m2 * (q >> 16)) >> 16;
  endfunction

  function automatic longint edge_dot(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint     u;
    longint     v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint mix(longint t, longint a, longint b);
    return a + floor_div(t * (b - a), 16);
  endfunction

  function automatic logic [15:0] noise_at(logic [31:0] cx, logic [31:0] cy,
                                           logic [31:0] cz);
    logic [7:0] xi, yi, zi, a, aa, ab, b, ba, bb;
    longint     x, y, z, x1, y1, z1, u, v, w, r;
    xi = cx[23:16];
    yi = cy[23:16];
    zi = cz[23:16];
    x = cx[15:0];
    y = cy[15:0];
    z = cz[15:0];
    x1 = x - 65536;
    y1 = y - 65536;
    z1 = z - 65536;
    u = fade_curve(x);
    v = fade_curve(y);
    w = fade_curve(z);
    a  = perm_model[xi] + yi;
    aa = perm_model[a] + zi;
    ab = perm_model[8'(a + 1)] + zi;
    b  = perm_model[8'(xi + 1)] + yi;
    ba = perm_model[b] + zi;
    bb = perm_model[8'(b + 1)] + zi;
    r = mix(w,
            mix(v, mix(u, edge_dot(perm_model[aa], x, y, z),
                          edge_dot(perm_model[ba], x1, y, z)),
                   mix(u, edge_dot(perm_model[ab], x, y1, z),
                          edge_dot(perm_model[bb], x1, y1, z))),
            mix(v, mix(u, edge_dot(perm_model[8'(aa + 1)], x, y, z1),
                          edge_dot(perm_model[8'(ba + 1)], x1, y, z1)),
                   mix(u, edge_dot(perm_model[8'(ab + 1)], x, y1, z1),
                          edge_dot(perm_model[8'(bb + 1)], x1, y1, z1))));
    r = floor_div(r, 2);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // Drive one item and hold it until taken; idle cycles drop start first.
  task automatic send_item(noise_item_t it);
    while ($urandom_range(99) < idle_cycles) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    op_i          <= it.op;
    entry_index_i <= it.idx;
    entry_value_i <= it.val;
    coord_x_i     <= it.cx;
    coord_y_i     <= it.cy;
    coord_z_i     <= it.cz;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (it.op == gn3_pkg::OP_WRITE) begin
      perm_model[it.idx] = it.val;
    end else if (it.has_known) begin
      noise_expected_q.push_back(it.known);
    end else begin
      noise_expected_q.push_back(noise_at(it.cx, it.cy, it.cz));
    end
  endtask

  function automatic noise_item_t eval_item(logic [31:0] cx, logic [31:0] cy,
                                            logic [31:0] cz);
    noise_item_t it;
    it.op = gn3_pkg::OP_EVAL;
    it.idx = 8'($urandom);
    it.val = 8'($urandom);
    it.cx = cx;
    it.cy = cy;
    it.cz = cz;
    it.has_known = 1'b0;
    it.known = '0;
    return it;
  endfunction

  function automatic noise_item_t write_item(logic [7:0] idx, logic [7:0] val);
    noise_item_t it;
    it = eval_item($urandom, $urandom, $urandom);
    it.op = gn3_pkg::OP_WRITE;
    it.idx = idx;
    it.val = val;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return {{16{1'b0}}, 16'($urandom)};
      2: return {{16{1'b1}}, 16'($urandom)};
      default: return {$urandom_range(3) == 0 ? 16'hffff : 16'($urandom),
                       $urandom_range(1) ? 16'h0000 : 16'hffff};
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (noise_expected_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN) $display("unexpected noise result %h", noise_value_o);
      end else begin
        if (noise_value_o !== noise_expected_q[0]) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("noise mismatch: expected %h actual %h",
                     noise_expected_q[0], noise_value_o);
        end
        void'(noise_expected_q.pop_front());
      end
    end
  end

  int stall_count;
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  noise_item_t directed [$];

  initial begin
    noise_item_t it;
    err_count = 0;
    idle_cycles = 15;
    rst_ni = 1'b0;
    start_i = 1'b0;
    op_i = gn3_pkg::OP_WRITE;
    entry_index_i = '0;
    entry_value_i = '0;
    coord_x_i = '0;
    coord_y_i = '0;
    coord_z_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole table first so no read hits an unwritten entry.
    for (int i = 0; i < 256; i++) send_item(write_item(8'(i), 8'($urandom)));

    // Integer lattice points give zero noise.
    it = eval_item(32'h0, 32'h0, 32'h0);
    it.has_known = 1'b1;
    directed.push_back(it);
    it = eval_item(32'h7fff_0000, 32'h8000_0000, 32'hffff_0000);
    it.has_known = 1'b1;
    directed.push_back(it);
    directed.push_back(eval_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    directed.push_back(eval_item(32'h8000_0000, 32'hffff_ffff, 32'h0000_ffff));
    directed.push_back(eval_item(32'hffff_ffff, 32'h8000_0001, 32'h0000_8000));
    directed.push_back(eval_item(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
    directed.push_back(write_item(8'h00, 8'hff));
    directed.push_back(write_item(8'hff, 8'h00));
    directed.push_back(eval_item(32'h00ff_4000, 32'h00ff_c000, 32'h00ff_0001));
    for (int h = 0; h < 16; h++) begin
      directed.push_back(write_item(8'h10, 8'(h)));
      directed.push_back(eval_item(32'h0010_1234, 32'h0020_abcd, 32'h0030_5678));
    end
    foreach (directed[i]) send_item(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) idle_cycles = 0;
      if (n == RANDOM_ITEMS / 2) idle_cycles = 15;
      if ($urandom_range(9) == 0) send_item(write_item(8'($urandom), 8'($urandom)));
      else send_item(eval_item(rand_coord(), rand_coord(), rand_coord()));
    end
    start_i <= 1'b0;

    while (noise_expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
